### hdl/assert_macros.svh
// Assertion macros shared by the CRC engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/pcrc_pkg.sv
// Types, constants and helper functions of the parameterized CRC engine.
package pcrc_pkg;

	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [6:0]  RST_WIDTH  = 7'd32;
	localparam logic [63:0] RST_POLY   = 64'h0000_0000_04C1_1DB7;
	localparam logic [63:0] RST_INIT   = 64'h0000_0000_FFFF_FFFF;
	localparam logic        RST_REFIN  = 1'b1;
	localparam logic        RST_REFOUT = 1'b1;
	localparam logic [63:0] RST_FXOR   = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES   = '1;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_POLY   = 3'd1,
		REG_INIT   = 3'd2,
		REG_REFIN  = 3'd3,
		REG_REFOUT = 3'd4,
		REG_FXOR   = 3'd5
	} cfg_reg_t;

	// One queued message byte.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       last;
	} item_t;

	// Settings derived from the configuration registers.
	typedef struct packed {
		logic [63:0] mask;
		logic [5:0]  sh;
		logic [63:0] poly_al;
		logic [63:0] poly_rf;
		logic [63:0] init_ld;
		logic        refl;
		logic        flip;
		logic [63:0] fxor;
	} cfg_t;

	// Raw CRC waiting to be finalized.
	typedef struct packed {
		logic        valid;
		logic [63:0] raw;
	} res_t;

	function automatic logic [63:0] rev64(logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = v[63-i];
		end
		return r;
	endfunction

	function automatic cfg_t derive(logic [6:0] w, logic [63:0] poly, logic [63:0] init,
			logic ri, logic ro, logic [63:0] fx);
		cfg_t       d;
		logic [5:0] sh;
		// Saturate the width to 8..64 and keep 64 - width.
		if (w < 7'd8) begin
			sh = 6'd56;
		end else if (w > 7'd64) begin
			sh = 6'd0;
		end else begin
			sh = 6'(7'd64 - w);
		end
		d.sh      = sh;
		d.mask    = ALL_ONES >> sh;
		d.poly_al = poly << sh;
		d.poly_rf = rev64(poly) >> sh;
		d.init_ld = ri ? (rev64(init) >> sh) : (init & d.mask);
		d.refl    = ri;
		d.flip    = ri ^ ro;
		d.fxor    = fx;
		return d;
	endfunction

endpackage

### hdl/parameterized_crc_engine_unit.sv
// Top level of the parameterized CRC engine: configuration registers and datapath.
//
// Streaming CRC of 8 to 64 bits. Bytes enter on the s_ stream (tuser reloads the
// register from the initial value before the byte, tlast emits the finalized CRC after
// it) and results leave on the m_ stream, one per message. The engine takes one byte per
// clock while its queue has room and no cfg write holds input off, a rate set by the running
// CRC register, which folds a whole byte (eight bit steps of XOR logic) per cycle. A byte passes
// a four-entry queue, the update stage and the finalize/output register, in that order.
// Registers are written on the cfg port (index 0 width, 1 polynomial, 2 initial value,
// 3 reflect in, 4 reflect out, 5 final XOR); the user must write them only while no message
// is in flight, which the block does not enforce; input is held off in a write cycle.
module parameterized_crc_engine_unit import pcrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // end_of_message
	input  logic        s_tuser,    // start_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [63:0] crc_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [6:0]  width_q;
	logic [63:0] poly_q, init_q, fxor_q;
	logic        refin_q, refout_q;
	cfg_t        cfg_q;
	logic        cfg_wr;

	logic        q_valid, q_pop, fin_take;
	item_t       q_item;
	res_t        res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			poly_q   <= RST_POLY;
			init_q   <= RST_INIT;
			refin_q  <= RST_REFIN;
			refout_q <= RST_REFOUT;
			fxor_q   <= RST_FXOR;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[6:0];
				REG_POLY:   poly_q   <= cfg_data;
				REG_INIT:   init_q   <= cfg_data;
				REG_REFIN:  refin_q  <= cfg_data[0];
				REG_REFOUT: refout_q <= cfg_data[0];
				REG_FXOR:   fxor_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Precompute shift, mask and mirrored values in a register behind the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= derive(RST_WIDTH, RST_POLY, RST_INIT, RST_REFIN, RST_REFOUT, RST_FXOR);
		end else begin
			cfg_q <= derive(width_q, poly_q, init_q, refin_q, refout_q, fxor_q);
		end
	end

	pcrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (cfg_valid),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pcrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.fin_take (fin_take),
		.res      (res)
	);

	pcrc_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.res      (res),
		.fin_take (fin_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### hdl/pcrc_front.sv
// Input side: accepts message bytes and queues them for the CRC update.
`include "assert_macros.svh"

module pcrc_front import pcrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hold,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_message
	input  logic       s_tuser,   // start_of_message
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop, full;

	assign full     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	// Hold off input in the cycle of a configuration write.
	assign s_tready = !full && !hold;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: s_tdata, start: s_tuser, last: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_CLK_RST(a_cnt_up, clk, arst_n, push && !pop |=> count_q == $past(count_q) + 1'b1)
	`ASSERT_CLK_RST(a_cnt_dn, clk, arst_n, pop && !push |=> count_q == $past(count_q) - 1'b1)
	`ASSERT_NEVER(a_cnt_ovf, clk, arst_n, count_q > (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

### hdl/pcrc_back.sv
// Back side: folds each queued byte into the running CRC register.
module pcrc_back import pcrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	input  logic  fin_take,
	output res_t  res
);

	logic [63:0] run_q;
	logic [63:0] c_next;
	logic        res_valid_s1;
	logic [63:0] res_raw_s1;
	logic        s1_free;

	assign s1_free = !res_valid_s1 || fin_take;
	// Only a byte that ends a message needs room in the result stage.
	assign q_pop   = q_valid && (!q_item.last || s1_free);

	always_comb begin
		logic [63:0] c0, cr, ca;
		c0 = q_item.start ? cfg.init_ld : (run_q & cfg.mask);
		// Reflected form: LSB first with the mirrored polynomial.
		cr = c0 ^ {56'd0, q_item.data};
		for (int b = 0; b < 8; b++) begin
			cr = cr[0] ? ((cr >> 1) ^ cfg.poly_rf) : (cr >> 1);
		end
		// Normal form: left-align to bit 63 so the top bit is fixed.
		ca = (c0 << cfg.sh) ^ {q_item.data, 56'd0};
		for (int b = 0; b < 8; b++) begin
			ca = ca[63] ? ((ca << 1) ^ cfg.poly_al) : (ca << 1);
		end
		c_next = cfg.refl ? cr : (ca >> cfg.sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			if (q_pop) begin
				run_q <= c_next;
			end
			if (q_pop && q_item.last) begin
				res_valid_s1 <= 1'b1;
			end else if (fin_take) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			res_raw_s1 <= c_next;
		end
	end

	assign res = '{valid: res_valid_s1, raw: res_raw_s1};

endmodule

### hdl/pcrc_final.sv
// Finalization and output register: reflect, XOR and mask the CRC.
`include "assert_macros.svh"

module pcrc_final import pcrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  res_t        res,
	output logic        fin_take,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // [63:0] crc_value
);

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [63:0] fin;

	assign fin_take = !out_valid_q || m_tready;
	assign fin      = ((cfg.flip ? (rev64(res.raw) >> cfg.sh) : res.raw) ^ cfg.fxor) & cfg.mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take && res.valid) begin
			out_data_q <= fin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ASSERT_CLK_RST(a_res_hold, clk, arst_n, res.valid && !fin_take |=> res.valid && $stable(res.raw))

endmodule

### tb/crc_checker.sv
// Checker for the CRC engine: tracks configuration, predicts each CRC and compares results.
`timescale 1ns / 1ps

module crc_checker import pcrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // end_of_message
	input  logic        s_tuser,    // start_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,    // [63:0] crc_value
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);

	logic [6:0]  width_r;
	logic [63:0] poly_r;
	logic [63:0] init_r;
	logic        refin_r;
	logic        refout_r;
	logic [63:0] fxor_r;

	logic [63:0] crc_reg;
	logic [63:0] expected_crcs[$];
	int          err_cnt;

	logic [63:0] width_m;
	logic [63:0] crc_out;
	logic [63:0] crc_exp;
	int unsigned width_n;

	// Clamp the programmed width to 8..64.
	function automatic int unsigned eff_width(logic [6:0] w);
		if (w < 7'd8) begin
			return 8;
		end else if (w > 7'd64) begin
			return 64;
		end
		return {25'd0, w};
	endfunction

	function automatic logic [63:0] low_ones(int unsigned w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	// Mirror the low w bits.
	function automatic logic [63:0] mirror_low(logic [63:0] v, int unsigned w);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < w; i++) begin
			r[w-1-i] = v[i];
		end
		return r;
	endfunction

	// Fold one byte into the running register; poly is already masked to the width.
	function automatic logic [63:0] fold_byte(logic [63:0] crc, logic [7:0] d, int unsigned w,
			logic [63:0] poly, logic refl);
		logic [63:0] m;
		logic [63:0] c;
		logic [63:0] rpoly;
		logic [63:0] top;
		m = low_ones(w);
		c = crc & m;
		if (refl) begin
			rpoly = mirror_low(poly, w);
			c = c ^ {56'd0, d};
			for (int b = 0; b < 8; b++) begin
				c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
			end
		end else begin
			top = 64'd1 << (w - 1);
			c = c ^ ({56'd0, d} << (w - 8));
			for (int b = 0; b < 8; b++) begin
				c = ((c & top) != 0) ? (((c << 1) ^ poly) & m) : ((c << 1) & m);
			end
		end
		return c & m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_r  = RST_WIDTH;
			poly_r   = RST_POLY;
			init_r   = RST_INIT;
			refin_r  = RST_REFIN;
			refout_r = RST_REFOUT;
			fxor_r   = RST_FXOR;
			crc_reg  = '0;
			expected_crcs.delete();
			err_cnt  = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  width_r  = cfg_data[6:0];
					REG_POLY:   poly_r   = cfg_data;
					REG_INIT:   init_r   = cfg_data;
					REG_REFIN:  refin_r  = cfg_data[0];
					REG_REFOUT: refout_r = cfg_data[0];
					REG_FXOR:   fxor_r   = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				width_n = eff_width(width_r);
				width_m = low_ones(width_n);
				// Reload before the byte; the reflected form keeps the init mirrored.
				if (s_tuser) begin
					crc_reg = refin_r ? mirror_low(init_r & width_m, width_n)
						: (init_r & width_m);
				end
				crc_reg = fold_byte(crc_reg, s_tdata, width_n, poly_r & width_m, refin_r);
				if (s_tlast) begin
					crc_out = (refin_r != refout_r) ? mirror_low(crc_reg, width_n) : crc_reg;
					expected_crcs.push_back((crc_out ^ fxor_r) & width_m);
				end
			end

			if (m_tvalid && m_tready) begin
				if (expected_crcs.size() == 0) begin
					$display("%0t: unexpected crc_value transfer, expected none, actual %h",
						$time, m_tdata);
					err_cnt++;
				end else begin
					crc_exp = expected_crcs.pop_front();
					if (m_tdata !== crc_exp) begin
						$display("%0t: crc_value mismatch, expected %h, actual %h",
							$time, crc_exp, m_tdata);
						err_cnt++;
					end
				end
			end

			errors  <= err_cnt;
			pending <= expected_crcs.size();
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the CRC engine: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top import pcrc_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          SETTLE_DELAY = 8;
	localparam int          NUM_PHASES   = 12;
	localparam int          PHASE_BYTES  = 115;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	int          errors;
	int          pending;
	int          send_idle;
	int          recv_idle;
	int          byte_count;
	bit          hold_req;
	int unsigned cycle_count;

	parameterized_crc_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crc_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("parameterized_crc_engine_unit test failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Call at a rising edge; returns at the edge of the transfer with tvalid still high.
	task automatic send_byte(input logic [7:0] d, input logic st, input logic la);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= st;
		s_tlast  <= la;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		byte_count++;
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Drop tvalid, wait for every CRC, then let the pipeline drain trailing bytes.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_DELAY) @(posedge clk);
	endtask

	task automatic load_setting(input logic [6:0] w, input logic [63:0] poly,
			input logic [63:0] init, input logic ri, input logic ro, input logic [63:0] fx);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		settle();
		// Upper bits of the narrow registers carry junk; they must be dropped.
		cfg_write(REG_WIDTH, {junk[63:7], w});
		cfg_write(REG_POLY, poly);
		cfg_write(REG_INIT, init);
		cfg_write(REG_REFIN, {junk[63:1], ri});
		cfg_write(REG_REFOUT, {junk[62:0], ro});
		cfg_write(REG_FXOR, fx);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed messages; now and then a missing start, stray flags or no end.
	task automatic send_message();
		int  len;
		bit  broken;
		bit  first_start;
		bit  st;
		bit  la;
		len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
		broken = ($urandom_range(19) == 0);
		first_start = ($urandom_range(9) != 0);
		for (int i = 0; i < len; i++) begin
			st = (i == 0) ? first_start : ($urandom_range(29) == 0);
			la = (i == len - 1) ? !broken : ($urandom_range(29) == 0);
			send_byte(8'($urandom_range(255)), st, la);
		end
	endtask

	initial begin
		logic [6:0] w;
		int         phase_start;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tlast     <= 1'b0;
		s_tuser     <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_WIDTH;
		cfg_data    <= '0;
		send_idle   = 0;
		recv_idle   = 0;
		byte_count  = 0;
		hold_req    = 1'b0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: run from the zero register before any start.
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b1);
		for (int i = 0; i < 9; i++) begin
			send_byte(8'h31 + 8'(i), i == 0, i == 8);
		end
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);

		// Narrowest width; continue the old register without a start.
		load_setting(7'd8, 64'h07, 64'h00, 1'b0, 1'b0, 64'h00);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h80, 1'b1, 1'b1);

		// Width above range saturates to 64; all-ones values, reflect out only.
		load_setting(7'd127, '1, '1, 1'b0, 1'b1, '1);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);

		// Width below range saturates to 8; zero polynomial, reflect in only.
		load_setting(7'd0, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0);
		send_byte(8'h01, 1'b1, 1'b1);
		send_byte(8'hFE, 1'b0, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 6)
				0: w = 7'd8;
				1: w = 7'd64;
				2: w = 7'd16;
				3: w = 7'($urandom_range(127));
				4: w = 7'd32;
				default: w = 7'($urandom_range(63, 9));
			endcase
			load_setting(w, {$urandom, $urandom} | 64'h1, {$urandom, $urandom},
				(p < 4) ? p[0] : 1'($urandom_range(1)),
				(p < 4) ? p[1] : 1'($urandom_range(1)),
				{$urandom, $urandom});
			if (p < 4) begin
				send_idle = 36;
				recv_idle = 65;
			end else if (p < 8) begin
				send_idle = 65;
				recv_idle = 36;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// Stall the output long enough for the engine to back up into its input.
			if (p == 8) begin
				hold_req = 1'b1;
			end
			phase_start = byte_count;
			while (byte_count - phase_start < PHASE_BYTES) begin
				send_message();
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("parameterized_crc_engine_unit test passed");
		end else begin
			$display("parameterized_crc_engine_unit test failed");
		end
		$finish;
	end

endmodule
